>>> sv/mwts_pkg.sv
package mwts_pkg;

	// waveform select codes
	typedef enum logic [2:0] {
		WF_SINE     = 3'd0,
		WF_SQUARE   = 3'd1,
		WF_TRIANGLE = 3'd2,
		WF_RAMP     = 3'd3,
		WF_NOISE    = 3'd4
	} wave_t;

	// register indexes on the config port
	typedef enum logic [2:0] {
		REG_WAVEFORM      = 3'd0,
		REG_INVERT        = 3'd1,
		REG_VOLUME        = 3'd2,
		REG_PHASE_STEP    = 3'd3,
		REG_CHANNEL_COUNT = 3'd4
	} reg_idx_t;

	// Q2.15 waveform value, -32768..32768
	typedef logic signed [16:0] wave_val_t;

	localparam logic [2:0]  WAVEFORM_RST      = 3'd0;
	localparam logic        INVERT_RST        = 1'b0;
	localparam logic [15:0] VOLUME_RST        = 16'd32768;
	localparam logic [31:0] PHASE_STEP_RST    = 32'd39370534;
	localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd2;

	localparam logic [15:0] FULL_VOLUME = 16'd32768;
	localparam logic [31:0] LFSR_SEED   = 32'h2545_F491;
	localparam logic [31:0] LFSR_TAPS   = 32'hA300_0000;
	localparam longint      HALF_PI_Q30 = 64'sd1686629713;

	// series divisors (2k)(2k+1), k = 1..9, as reciprocals scaled by 2^48;
	// exact for the nonnegative terms below 2^33 that the series produces
	localparam int     SERIES_SHIFT = 48;
	localparam longint SERIES_RECIP [9] = '{
		(longint'(1) <<< SERIES_SHIFT) / 6 + 1,
		(longint'(1) <<< SERIES_SHIFT) / 20 + 1,
		(longint'(1) <<< SERIES_SHIFT) / 42 + 1,
		(longint'(1) <<< SERIES_SHIFT) / 72 + 1,
		(longint'(1) <<< SERIES_SHIFT) / 110 + 1,
		(longint'(1) <<< SERIES_SHIFT) / 156 + 1,
		(longint'(1) <<< SERIES_SHIFT) / 210 + 1,
		(longint'(1) <<< SERIES_SHIFT) / 272 + 1,
		(longint'(1) <<< SERIES_SHIFT) / 342 + 1
	};

	// Quarter-wave sine entry: Taylor series in Q30, rounded to Q1.15.
	// Only evaluated at elaboration to fill the ROM.
	function automatic logic [15:0] quarter_sine(input longint idx, input int addr_bits);
		longint x;
		longint x2;
		longint term;
		longint sum;
		logic [95:0] prod;
		x = (idx * HALF_PI_Q30) >>> addr_bits;
		x2 = (x * x) >>> 30;
		term = x;
		sum = x;
		for (int k = 1; k <= 9; k++) begin
			term = (term * x2) >>> 30;
			prod = 96'(term) * 96'(SERIES_RECIP[k - 1]);
			term = longint'(prod >> SERIES_SHIFT);
			if (k[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		return 16'((sum * 32768 + (longint'(1) <<< 29)) >>> 30);
	endfunction

endpackage

>>> sv/multi_waveform_tone_synth_top.sv
// A frame word passes the stage 1, stage 2 and stage 3 registers, then the output
// register. One frame per cycle enters the pipe unless frame_stall is high; one sample
// word per cycle leaves unless sample_stall is high; N channels give N sample words.
// Frames with a channel count of zero pass through and emit nothing.
// Reset (arst_n low, async): pipe emptied, phase cleared, LFSR seeded, registers
// back to their defaults. The sine ROM is constant and needs no fill.
module multi_waveform_tone_synth_top
	import mwts_pkg::*;
#(
	parameter int SINE_ADDR_BITS = 10,
	parameter int MAX_CHANNELS   = 8
) (
	input  logic               clk,
	input  logic               arst_n,

	// config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,

	// frame channel
	input  logic               frame_valid,
	output logic               frame_stall,
	input  logic               restart,

	// sample channel
	output logic               sample_valid,
	input  logic               sample_stall,
	output logic signed [15:0] sample,
	output logic [2:0]         channel,
	output logic               last
);

	localparam int TABLE_SIZE = 1 << SINE_ADDR_BITS;
	localparam int CH_W       = $clog2(MAX_CHANNELS + 1);

	// config registers
	logic [2:0]  waveform_q;
	logic        invert_q;
	logic [15:0] volume_q;
	logic [31:0] phase_step_q;
	logic [3:0]  channel_count_q;

	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q      <= WAVEFORM_RST;
			invert_q        <= INVERT_RST;
			volume_q        <= VOLUME_RST;
			phase_step_q    <= PHASE_STEP_RST;
			channel_count_q <= CHANNEL_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WAVEFORM:      waveform_q      <= pwdata[2:0];
				REG_INVERT:        invert_q        <= pwdata[0];
				REG_VOLUME:        volume_q        <= pwdata[15:0];
				REG_PHASE_STEP:    phase_step_q    <= pwdata;
				REG_CHANNEL_COUNT: channel_count_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			REG_WAVEFORM:      prdata = {29'd0, waveform_q};
			REG_INVERT:        prdata = {31'd0, invert_q};
			REG_VOLUME:        prdata = {16'd0, volume_q};
			REG_PHASE_STEP:    prdata = phase_step_q;
			REG_CHANNEL_COUNT: prdata = {28'd0, channel_count_q};
			default:           prdata = 32'd0;
		endcase
	end

	// effective channel count, capped at MAX_CHANNELS
	logic [CH_W-1:0] n_ch;
	assign n_ch = (32'(channel_count_q) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS)
		: CH_W'(channel_count_q);

	// quarter-wave sine ROM, built at elaboration
	logic [15:0] sine_rom [TABLE_SIZE];

	for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
		localparam logic [15:0] ENTRY = quarter_sine(longint'(gi), SINE_ADDR_BITS);
		assign sine_rom[gi] = ENTRY;
	end

	// pipe handshake
	logic v_s1, v_s2, v_s3;
	logic ready1, ready2, ready3;
	logic in_acc;
	logic sample_valid_q;
	logic [CH_W-1:0] chan_q;
	logic last_w, out_take, out_done, out_free, load_out;

	assign last_w   = (chan_q + CH_W'(1)) == n_ch;
	assign out_take = sample_valid_q && !sample_stall;
	assign out_done = out_take && last_w;
	assign out_free = !sample_valid_q || out_done;
	assign load_out = v_s3 && (n_ch != '0) && out_free;

	assign ready3      = !v_s3 || (n_ch == '0) || out_free;
	assign ready2      = !v_s2 || ready3;
	assign ready1      = !v_s1 || ready2;
	assign frame_stall = !ready1;
	assign in_acc      = frame_valid && ready1;

	// phase and noise state, frame input decode
	logic [31:0] phase_acc_q;
	logic [31:0] lfsr_q;
	logic [31:0] phase;
	logic [31:0] lfsr_next;

	assign phase     = restart ? 32'd0 : phase_acc_q;
	assign lfsr_next = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			lfsr_q      <= LFSR_SEED;
		end else if (in_acc) begin
			phase_acc_q <= phase + phase_step_q;
			if (waveform_q == WF_NOISE) begin
				lfsr_q <= lfsr_next;
			end
		end
	end

	// sine address with quadrant mirroring
	logic [SINE_ADDR_BITS-1:0] sin_idx;
	logic [SINE_ADDR_BITS-1:0] rom_addr;
	logic                      sin_full;

	assign sin_idx  = phase[29 -: SINE_ADDR_BITS];
	assign rom_addr = phase[30] ? SINE_ADDR_BITS'(~sin_idx + 1'b1) : sin_idx;
	assign sin_full = phase[30] && (sin_idx == '0);

	// non-sine waveform values
	logic [32:0]        tri_down;
	logic signed [17:0] tri_val;
	wave_val_t          w_alt;

	assign tri_down = 33'h1_0000_0000 - {1'b0, phase};

	always_comb begin
		if (!phase[31]) begin
			tri_val = $signed({2'b00, phase[30:15]}) - 18'sd32768;
		end else begin
			tri_val = $signed({1'b0, tri_down[31:15]}) - 18'sd32768;
		end
		unique case (waveform_q)
			WF_SQUARE:   w_alt = phase[31] ? -17'sd32768 : 17'sd32768;
			WF_TRIANGLE: w_alt = tri_val[16:0];
			WF_RAMP:     w_alt = {{2{~phase[31]}}, phase[30:16]};
			WF_NOISE:    w_alt = {{2{~lfsr_next[30]}}, lfsr_next[29:15]};
			default:     w_alt = '0;
		endcase
	end

	// stage 1: ROM read and waveform select inputs
	logic [15:0] rom_s1;
	logic        full_s1;
	logic        neg_s1;
	wave_val_t   walt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready1) begin
			v_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rom_s1  <= sine_rom[rom_addr];
			full_s1 <= sin_full;
			neg_s1  <= phase[31];
			walt_s1 <= w_alt;
		end
	end

	// stage 2: waveform value times volume, Q2.30
	wave_val_t          sin_mag;
	wave_val_t          w_sel;
	wave_val_t          w_eff;
	logic signed [17:0] vol_s;
	logic signed [31:0] q_s2;

	assign sin_mag = full_s1 ? 17'sd32768 : $signed({1'b0, rom_s1});
	assign w_sel   = (waveform_q == WF_SINE) ? (neg_s1 ? -sin_mag : sin_mag) : walt_s1;
	assign w_eff   = invert_q ? -w_sel : w_sel;
	assign vol_s   = (volume_q > FULL_VOLUME) ? $signed({2'b00, FULL_VOLUME})
		: $signed({2'b00, volume_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && ready2) begin
			q_s2 <= 32'(w_eff * vol_s);
		end
	end

	// stage 3: scale to PCM with rounding offset
	logic signed [47:0] num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && ready3) begin
			num_s3 <= 48'(q_s2) * 48'sd32767 + 48'sd536870912;
		end
	end

	// divide by 2^30 toward zero, then clamp
	logic signed [17:0] quo;
	logic signed [15:0] pcm;

	always_comb begin
		quo = 18'(num_s3 >>> 30);
		if (num_s3[47] && (num_s3[29:0] != '0)) begin
			quo = quo + 18'sd1;
		end
		if (quo > 18'sd32767) begin
			pcm = 16'sd32767;
		end else if (quo < -18'sd32767) begin
			pcm = -16'sd32767;
		end else begin
			pcm = quo[15:0];
		end
	end

	// output register, replays the sample once per channel
	logic signed [15:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid_q <= 1'b0;
			chan_q         <= '0;
		end else if (load_out) begin
			sample_valid_q <= 1'b1;
			chan_q         <= '0;
		end else if (out_done) begin
			sample_valid_q <= 1'b0;
		end else if (out_take) begin
			chan_q <= chan_q + CH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sample_q <= pcm;
		end
	end

	assign sample_valid = sample_valid_q;
	assign sample       = sample_q;
	assign channel      = 3'(chan_q);
	assign last         = last_w;

	// checks
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid_q |-> (chan_q < n_ch))
		else $error("channel index beyond frame channel count");

	a_no_neg_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid_q |-> (sample_q != -16'sd32768))
		else $error("sample outside symmetric PCM range");

	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !restart) |=> (phase_acc_q == $past(phase_acc_q + phase_step_q)))
		else $error("phase accumulator did not advance by the step");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid_q && sample_stall) |=> (sample_valid_q && $stable(chan_q)))
		else $error("stalled sample word moved on");

	a_zero_ch_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(n_ch == '0) |-> !load_out)
		else $error("empty frame loaded the output register");

endmodule
